### rtl/rde_pkg.sv
// shared widths, register codes, reset values and digit table lookup
package rde_pkg;

   localparam int NUMBER_W        = 32;
   localparam int DIGIT_CHAR_W    = 8;
   localparam int CHAR_COUNT_W    = 6;
   localparam int RADIX_W         = 5;
   localparam int CHARS_W         = 64;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 64;
   localparam int DIGIT_W         = 4;
   localparam int TABLE_DEPTH     = 16;
   localparam int DIV_STEP_BITS   = 8;

   localparam int DEF_NUMBER_WIDTH = 32;
   localparam int DEF_MAX_RADIX    = 16;

   localparam logic [RADIX_W-1:0] RESET_RADIX      = 5'd10;
   localparam logic [CHARS_W-1:0] RESET_CHARS_LOW  = 64'd3978425819141910832;
   localparam logic [CHARS_W-1:0] RESET_CHARS_HIGH = 64'd14648;

   localparam logic [DIGIT_CHAR_W-1:0] SIGN_MINUS = 8'h2D;
   localparam logic [DIGIT_CHAR_W-1:0] SIGN_PLUS  = 8'h2B;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RADIX      = 2'd0,
      CSR_CHARS_LOW  = 2'd1,
      CSR_CHARS_HIGH = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                 set_ok;
      logic [RADIX_W-1:0]   radix;
      logic [CHARS_W-1:0]   chars_low;
      logic [CHARS_W-1:0]   chars_high;
   } cfg_view_type;

   function automatic logic [DIGIT_CHAR_W-1:0] table_char(
      input logic [CHARS_W-1:0] chars_low,
      input logic [CHARS_W-1:0] chars_high,
      input logic [DIGIT_W-1:0] digit
   );
      logic [DIGIT_CHAR_W-1:0] ch;
      if (digit[DIGIT_W-1]) begin
         ch = chars_high[{digit[DIGIT_W-2:0], 3'b000} +: DIGIT_CHAR_W];
      end else begin
         ch = chars_low[{digit[DIGIT_W-2:0], 3'b000} +: DIGIT_CHAR_W];
      end
      return ch;
   endfunction

endpackage

### rtl/rde_req_if.sv
// input channel carrying the number to convert
interface rde_req_if;
   import rde_pkg::*;
   logic                valid;
   logic                ready;
   logic [NUMBER_W-1:0] number;
   modport source (output valid, number, input ready);
   modport sink (input valid, number, output ready);
endinterface

### rtl/rde_rsp_if.sv
// result channel carrying one digit character per transfer
interface rde_rsp_if;
   import rde_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [DIGIT_CHAR_W-1:0] digit_char;
   logic                    last_digit;
   logic [CHAR_COUNT_W-1:0] char_count;
   modport source (output valid, digit_char, last_digit, char_count, input ready);
   modport sink (input valid, digit_char, last_digit, char_count, output ready);
endinterface

### rtl/rde_csr_if.sv
// configuration write channel
interface rde_csr_if;
   import rde_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/radix_digit_emitter_unit.sv
// Number to digit string converter in a configurable radix, most significant digit first.
// Each digit is the remainder of one pass of the shared divider over the number so far,
// and the digits are stacked until the quotient is zero, then emitted from the stack.
// Digits leave one per cycle unless rsp.ready stalls; the next number is taken after the last.
// Reset: radix 10 and the table "0123456789"; digit stack and handshakes cleared.
module radix_digit_emitter_unit
   import rde_pkg::*;
#(
   parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH,
   parameter int MAX_RADIX    = DEF_MAX_RADIX
) (
   input  logic      clock,
   input  logic      reset,
   rde_req_if.sink   req,
   rde_rsp_if.source rsp,
   rde_csr_if.sink   csr
);

   localparam int EFF_W = (NUMBER_WIDTH < NUMBER_W) ? NUMBER_WIDTH : NUMBER_W;
   localparam int STEPS = (EFF_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
   localparam int DIV_W = STEPS * DIV_STEP_BITS;
   localparam int DEPTH = EFF_W;
   localparam int PTR_W = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_DIVIDE = 3'b010,
      S_EMIT   = 3'b100
   } state_type;

   state_type    state_ff, state_in;
   cfg_view_type cfg;

   logic               div_start;
   logic [DIV_W-1:0]   div_dividend;
   logic               div_done;
   logic [DIV_W-1:0]   div_quotient;
   logic [DIGIT_W-1:0] div_remainder;

   logic               stk_push;
   logic               stk_pop;
   logic [PTR_W-1:0]   stk_level;
   logic [DIGIT_W-1:0] stk_top;

   logic [CHAR_COUNT_W-1:0] total_ff, total_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_CHAR_W-1:0] digit_char_ff, digit_char_in;
   logic                    last_digit_ff, last_digit_in;
   logic [CHAR_COUNT_W-1:0] char_count_ff, char_count_in;
   logic                    req_xfer;
   logic                    out_load;
   logic                    is_last;

   rde_csr_regs #(
      .MAX_RADIX (MAX_RADIX)
   ) u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   rde_divider #(
      .DIV_W (DIV_W),
      .STEPS (STEPS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (cfg.radix),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   rde_digit_stack #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .push       (stk_push),
      .push_digit (div_remainder),
      .pop        (stk_pop),
      .level      (stk_level),
      .top_digit  (stk_top)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign req_xfer  = req.valid && req.ready;
   assign out_load  = !rsp_valid_ff || rsp.ready;
   assign is_last   = (stk_level == PTR_W'(1));

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      div_start     = 1'b0;
      div_dividend  = div_quotient;
      stk_push      = 1'b0;
      stk_pop       = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      digit_char_in = digit_char_ff;
      last_digit_in = last_digit_ff;
      char_count_in = char_count_ff;
      case (state_ff)
         S_IDLE: begin
            div_dividend = DIV_W'(req.number[EFF_W-1:0]);
            // an invalid digit set swallows the number without results
            if (req_xfer && cfg.set_ok) begin
               div_start = 1'b1;
               state_in  = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               stk_push = 1'b1;
               if (div_quotient == '0) begin
                  total_in = CHAR_COUNT_W'(stk_level) + CHAR_COUNT_W'(1);
                  state_in = S_EMIT;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         S_EMIT: begin
            if (out_load) begin
               stk_pop       = 1'b1;
               rsp_valid_in  = 1'b1;
               digit_char_in = table_char(cfg.chars_low, cfg.chars_high, stk_top);
               last_digit_in = is_last;
               char_count_in = is_last ? total_ff : '0;
               if (is_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff      <= total_in;
      digit_char_ff <= digit_char_in;
      last_digit_ff <= last_digit_in;
      char_count_ff <= char_count_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.digit_char = digit_char_ff;
   assign rsp.last_digit = last_digit_ff;
   assign rsp.char_count = char_count_ff;

   a_busy_after_xfer : assert property (@(posedge clock) disable iff (reset)
      (req_xfer && cfg.set_ok) |=> !req.ready)
      else $error("input still ready after a convertible number was taken");

   a_emit_has_digits : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (stk_level != '0))
      else $error("emitting with an empty digit stack");

   a_last_has_count : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.last_digit) |-> (rsp.char_count != '0))
      else $error("final digit carries no character count");

   a_idle_stack_empty : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (stk_level == '0))
      else $error("digits left on the stack after a number finished");

endmodule

### rtl/rde_csr_regs.sv
// configuration registers and digit set check
module rde_csr_regs
   import rde_pkg::*;
#(
   parameter int MAX_RADIX = DEF_MAX_RADIX
) (
   input  logic         clock,
   input  logic         reset,
   rde_csr_if.sink      csr,
   output cfg_view_type cfg
);

   logic [RADIX_W-1:0] radix_ff;
   logic [CHARS_W-1:0] chars_low_ff;
   logic [CHARS_W-1:0] chars_high_ff;
   logic               set_ok;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= RESET_RADIX;
         chars_low_ff  <= RESET_CHARS_LOW;
         chars_high_ff <= RESET_CHARS_HIGH;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_RADIX:      radix_ff      <= csr.data[RADIX_W-1:0];
            CSR_CHARS_LOW:  chars_low_ff  <= csr.data;
            CSR_CHARS_HIGH: chars_high_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // every pair of entries in use is compared at once
   always_comb begin
      logic [DIGIT_CHAR_W-1:0] ch [TABLE_DEPTH];
      logic [TABLE_DEPTH-1:0]  in_use;
      logic                    bad;
      bad = (radix_ff < RADIX_W'(2)) || (radix_ff > RADIX_W'(MAX_RADIX))
            || (radix_ff > RADIX_W'(TABLE_DEPTH));
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         ch[i]     = table_char(chars_low_ff, chars_high_ff, DIGIT_W'(i));
         in_use[i] = RADIX_W'(i) < radix_ff;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (in_use[i] && (ch[i] == SIGN_MINUS || ch[i] == SIGN_PLUS)) begin
            bad = 1'b1;
         end
         for (int j = i + 1; j < TABLE_DEPTH; j++) begin
            if (in_use[j] && ch[i] == ch[j]) begin
               bad = 1'b1;
            end
         end
      end
      set_ok = !bad;
   end

   assign cfg.set_ok     = set_ok;
   assign cfg.radix      = radix_ff;
   assign cfg.chars_low  = chars_low_ff;
   assign cfg.chars_high = chars_high_ff;

endmodule

### rtl/rde_divider.sv
// shared divider: one byte of quotient bits per cycle against the radix
module rde_divider
   import rde_pkg::*;
#(
   parameter int DIV_W = DEF_NUMBER_WIDTH,
   parameter int STEPS = DEF_NUMBER_WIDTH / DIV_STEP_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_W-1:0]   dividend,
   input  logic [RADIX_W-1:0] divisor,
   output logic               done,
   output logic [DIV_W-1:0]   quotient,
   output logic [DIGIT_W-1:0] remainder
);

   localparam int CNT_W = $clog2(STEPS + 1);

   logic [DIV_W-1:0]   work_ff, work_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   always_comb begin
      logic [DIV_W-1:0]   w;
      logic [RADIX_W-1:0] r;
      w = start ? dividend : work_ff;
      r = start ? '0 : {1'b0, rem_ff};
      for (int k = 0; k < DIV_STEP_BITS; k++) begin
         r = {r[DIGIT_W-1:0], w[DIV_W-1]};
         w = {w[DIV_W-2:0], 1'b0};
         if (r >= divisor) begin
            r    = r - divisor;
            w[0] = 1'b1;
         end
      end
      work_in = w;
      rem_in  = r[DIGIT_W-1:0];
   end

   always_comb begin
      if (start) begin
         cnt_in  = CNT_W'(STEPS - 1);
         busy_in = (STEPS > 1);
         done_in = (STEPS == 1);
      end else if (busy_ff) begin
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = cnt_ff > CNT_W'(1);
         done_in = cnt_ff == CNT_W'(1);
      end else begin
         cnt_in  = cnt_ff;
         busy_in = 1'b0;
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start || busy_ff) begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = work_ff;
   assign remainder = rem_ff;

endmodule

### rtl/rde_digit_stack.sv
// digit stack: remainders pushed least significant first, popped most significant first
module rde_digit_stack
   import rde_pkg::*;
#(
   parameter int DEPTH = DEF_NUMBER_WIDTH,
   parameter int PTR_W = $clog2(DEF_NUMBER_WIDTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [DIGIT_W-1:0] push_digit,
   input  logic               pop,
   output logic [PTR_W-1:0]   level,
   output logic [DIGIT_W-1:0] top_digit
);

   localparam int IDX_W = $clog2(DEPTH);

   logic [DIGIT_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]   level_ff, level_in;
   logic [PTR_W-1:0]   below;

   assign below = level_ff - PTR_W'(1);

   always_comb begin
      level_in = level_ff;
      if (push) begin
         level_in = level_ff + PTR_W'(1);
      end else if (pop) begin
         level_in = below;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[level_ff[IDX_W-1:0]] <= push_digit;
      end
   end

   assign level     = level_ff;
   assign top_digit = mem_ff[below[IDX_W-1:0]];

endmodule
